// ===== rtl/cdf_pkg.sv =====
// Shared constants for the CRC-8 framed serial deframer.
package cdf_pkg;

	// Byte window
	localparam int unsigned WIN_DEPTH = 16;
	localparam int unsigned WIN_IDX_W = $clog2(WIN_DEPTH);
	localparam int unsigned FILL_W    = $clog2(WIN_DEPTH + 1);

	// Frame lengths in bytes
	localparam logic [FILL_W-1:0] LEN_STD = FILL_W'(13);
	localparam logic [FILL_W-1:0] LEN_EXT = FILL_W'(16);

	// Frame start within the window (the oldest byte has index 0)
	localparam logic [WIN_IDX_W-1:0] BASE_STD = WIN_IDX_W'(WIN_DEPTH - 13);
	localparam logic [WIN_IDX_W-1:0] BASE_EXT = WIN_IDX_W'(WIN_DEPTH - 16);

	// Bit counter over the CRC-covered bytes
	localparam int unsigned     BIT_CNT_W    = 7;
	localparam logic [BIT_CNT_W-1:0] SCAN_LAST_STD = BIT_CNT_W'((13 - 2) * 8 - 1);
	localparam logic [BIT_CNT_W-1:0] SCAN_LAST_EXT = BIT_CNT_W'((16 - 2) * 8 - 1);

	// Fixed window positions; DLC, data, CRC and check byte are shared by both frame formats
	localparam int unsigned POS_DLC   = 5;
	localparam int unsigned POS_DATA  = 6;
	localparam int unsigned POS_CRC   = 14;
	localparam int unsigned POS_CMP   = 15;
	localparam int unsigned POS_ID_STD = 3;
	localparam int unsigned POS_ID_EXT = 0;
	localparam int unsigned POS_XID   = 2;

	// CRC-8, polynomial x^8 + x^2 + x + 1, MSB first
	localparam logic [7:0] CRC_INIT = 8'h41;
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_CMP_MASK = 8'hFF;

	// Field limits
	localparam logic [3:0] MAX_DLC = 4'd8;

	// Field widths
	localparam int unsigned STD_ID_W = 11;
	localparam int unsigned EXT_ID_W = 18;
	localparam int unsigned DLC_W    = 4;
	localparam int unsigned NUM_DATA = 8;

endpackage

// ===== rtl/cdf_if.sv =====
// Channel interfaces: received bytes in, decoded frames out.
interface cdf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cdf_frame_if;
	logic                           valid;
	logic                           ready;
	logic [cdf_pkg::STD_ID_W-1:0]   std_id;
	logic [cdf_pkg::EXT_ID_W-1:0]   ext_id;
	logic [cdf_pkg::DLC_W-1:0]      length_code;
	logic                           is_extended;
	logic [7:0]                     byte0;
	logic [7:0]                     byte1;
	logic [7:0]                     byte2;
	logic [7:0]                     byte3;
	logic [7:0]                     byte4;
	logic [7:0]                     byte5;
	logic [7:0]                     byte6;
	logic [7:0]                     byte7;

	modport source (output valid, output std_id, output ext_id, output length_code,
		output is_extended, output byte0, output byte1, output byte2, output byte3,
		output byte4, output byte5, output byte6, output byte7, input ready);
	modport sink (input valid, input std_id, input ext_id, input length_code,
		input is_extended, input byte0, input byte1, input byte2, input byte3,
		input byte4, input byte5, input byte6, input byte7, output ready);
endinterface

// ===== rtl/cdf_crc8.sv =====
// Bit-serial CRC-8 register, one message bit per cycle while shift_en is high, MSB first.
module cdf_crc8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clear,
	input  logic       shift_en,
	input  logic       din,
	output logic [7:0] crc
);

	logic [7:0] crc_q;
	logic       fb;

	assign fb  = din ^ crc_q[7];
	assign crc = crc_q;

	// LFSR update; clear reloads the seed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= cdf_pkg::CRC_INIT;
		end else if (clear) begin
			crc_q <= cdf_pkg::CRC_INIT;
		end else if (shift_en) begin
			crc_q <= {crc_q[6:0], 1'b0} ^ (fb ? cdf_pkg::CRC_POLY : 8'h00);
		end
	end

endmodule

// ===== rtl/crc8_can_frame_deframer.sv =====
// Top level: byte window, bit-serial frame check and output register.
//
// Usage:
//   rx    - one received serial byte per transaction (valid/ready).
//   frame - one decoded frame per transaction: IDs, DLC and eight data bytes.
//   cfg_wr_en / cfg_wr_data - ext_mode register, written while idle.
// Each byte enters a 16-byte shift window. Once the window holds a full frame
// (13 bytes standard, 16 extended) the CRC is run one bit per cycle over the
// covered bytes. A judge step then checks the frame, so a byte that completes
// a frame holds rx.ready low through the scan and the judge step, which also
// waits while a passing frame finds the output register full; a byte that does
// not complete a frame leaves rx.ready high. A passing frame appears on frame
// the cycle after the judge step loads it.
// The output register holds a frame until it is taken; rx keeps accepting
// bytes meanwhile, and only a second completed frame that passes its checks
// waits in the judge step for the register to free up.
// Reset clears the fill count (not the window contents), clears ext_mode and drops frame.valid.
module crc8_can_frame_deframer (
	input  logic              clk,
	input  logic              arst_n,
	cdf_byte_if.sink          rx,
	cdf_frame_if.source       frame,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_JUDGE
	} state_t;

	state_t                             state_q;
	logic                               ext_mode_q;
	logic [cdf_pkg::FILL_W-1:0]         fill_q;
	logic [cdf_pkg::BIT_CNT_W-1:0]      bit_cnt_q;
	logic [7:0]                         win_q [cdf_pkg::WIN_DEPTH];

	logic                               out_valid_q;
	logic [cdf_pkg::STD_ID_W-1:0]       std_id_q;
	logic [cdf_pkg::EXT_ID_W-1:0]       ext_id_q;
	logic [cdf_pkg::DLC_W-1:0]          dlc_q;
	logic                               is_ext_q;
	logic [7:0]                         data_q [cdf_pkg::NUM_DATA];

	logic                               accept;
	logic [cdf_pkg::FILL_W-1:0]         frame_len;
	logic [cdf_pkg::FILL_W-1:0]         fill_next;
	logic [cdf_pkg::BIT_CNT_W-1:0]      scan_last;
	logic [cdf_pkg::WIN_IDX_W-1:0]      scan_idx;
	logic [7:0]                         scan_byte;
	logic                               scan_bit;
	logic [7:0]                         crc;
	logic [7:0]                         id_hi;
	logic [7:0]                         id_lo;
	logic                               frame_ok;
	logic                               out_free;
	logic                               load_out;

	assign accept    = rx.valid && rx.ready;
	assign rx.ready  = (state_q == ST_IDLE);
	assign frame_len = ext_mode_q ? cdf_pkg::LEN_EXT : cdf_pkg::LEN_STD;
	assign scan_last = ext_mode_q ? cdf_pkg::SCAN_LAST_EXT : cdf_pkg::SCAN_LAST_STD;
	assign fill_next = (fill_q == cdf_pkg::FILL_W'(cdf_pkg::WIN_DEPTH)) ?
		fill_q : fill_q + cdf_pkg::FILL_W'(1);
	assign out_free  = !out_valid_q || frame.ready;
	assign load_out  = (state_q == ST_JUDGE) && frame_ok && out_free;

	// Serial read of the frame: byte from the window, bit MSB first
	assign scan_idx  = (ext_mode_q ? cdf_pkg::BASE_EXT : cdf_pkg::BASE_STD) +
		cdf_pkg::WIN_IDX_W'(bit_cnt_q[cdf_pkg::BIT_CNT_W-1:3]);
	assign scan_byte = win_q[scan_idx];
	assign scan_bit  = scan_byte[~bit_cnt_q[2:0]];

	cdf_crc8 u_crc (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (accept),
		.shift_en (state_q == ST_SCAN),
		.din      (scan_bit),
		.crc      (crc)
	);

	// Frame checks on fixed window positions
	assign id_hi = ext_mode_q ? win_q[cdf_pkg::POS_ID_EXT] : win_q[cdf_pkg::POS_ID_STD];
	assign id_lo = ext_mode_q ? win_q[cdf_pkg::POS_ID_EXT+1] :
		win_q[cdf_pkg::POS_ID_STD+1];

	always_comb begin
		frame_ok = (crc == win_q[cdf_pkg::POS_CRC]) &&
			((crc ^ cdf_pkg::CRC_CMP_MASK) == win_q[cdf_pkg::POS_CMP]) &&
			(id_hi[7:3] == 5'd0) &&
			(win_q[cdf_pkg::POS_DLC] <= 8'(cdf_pkg::MAX_DLC));
		if (ext_mode_q && (win_q[cdf_pkg::POS_XID][7:2] != 6'd0)) begin
			frame_ok = 1'b0;
		end
	end

	// Byte window: newest byte at the top
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < cdf_pkg::WIN_DEPTH - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[cdf_pkg::WIN_DEPTH-1] <= rx.rx_byte;
		end
	end

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			ext_mode_q <= cfg_wr_data;
		end
	end

	// Sequencer, fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			std_id_q    <= '0;
			ext_id_q    <= '0;
			dlc_q       <= '0;
			is_ext_q    <= 1'b0;
			for (int k = 0; k < cdf_pkg::NUM_DATA; k++) begin
				data_q[k] <= '0;
			end
		end else begin
			// taken frame frees the register unless a new one loads now
			if (out_valid_q && frame.ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q    <= fill_next;
						bit_cnt_q <= '0;
						if (fill_next >= frame_len) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					bit_cnt_q <= bit_cnt_q + cdf_pkg::BIT_CNT_W'(1);
					if (bit_cnt_q == scan_last) begin
						state_q <= ST_JUDGE;
					end
				end
				ST_JUDGE: begin
					if (!frame_ok) begin
						fill_q  <= frame_len - cdf_pkg::FILL_W'(1);
						state_q <= ST_IDLE;
					end else if (out_free) begin
						fill_q      <= '0;
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						std_id_q    <= {id_hi[2:0], id_lo};
						ext_id_q    <= ext_mode_q ? {win_q[cdf_pkg::POS_XID][1:0],
							win_q[cdf_pkg::POS_XID+1], win_q[cdf_pkg::POS_XID+2]} : '0;
						dlc_q       <= win_q[cdf_pkg::POS_DLC][cdf_pkg::DLC_W-1:0];
						is_ext_q    <= ext_mode_q;
						for (int k = 0; k < cdf_pkg::NUM_DATA; k++) begin
							data_q[k] <= win_q[cdf_pkg::POS_DATA+k];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign frame.valid       = out_valid_q;
	assign frame.std_id      = std_id_q;
	assign frame.ext_id      = ext_id_q;
	assign frame.length_code = dlc_q;
	assign frame.is_extended = is_ext_q;
	assign frame.byte0       = data_q[0];
	assign frame.byte1       = data_q[1];
	assign frame.byte2       = data_q[2];
	assign frame.byte3       = data_q[3];
	assign frame.byte4       = data_q[4];
	assign frame.byte5       = data_q[5];
	assign frame.byte6       = data_q[6];
	assign frame.byte7       = data_q[7];

endmodule

// ===== rtl/cdf_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
module cdf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          frame_valid,
	input logic                          frame_ready,
	input logic [cdf_pkg::STD_ID_W-1:0]  std_id,
	input logic [cdf_pkg::EXT_ID_W-1:0]  ext_id,
	input logic [cdf_pkg::DLC_W-1:0]     length_code,
	input logic                          is_extended
);

	// A stalled frame stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && !frame_ready) |=> frame_valid)
		else $error("frame.valid dropped while stalled");

	// A stalled frame keeps its identifiers
	a_id_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && !frame_ready) |=> ($stable(std_id) && $stable(ext_id)))
		else $error("frame identifiers changed while stalled");

	// Only frames with a legal DLC are passed on
	a_dlc_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> (length_code <= cdf_pkg::MAX_DLC))
		else $error("frame with DLC above 8");

	// Standard frames carry no extended identifier
	a_std_no_xid: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && !is_extended) |-> (ext_id == '0))
		else $error("standard frame with non-zero ext_id");

endmodule

bind crc8_can_frame_deframer cdf_checker u_cdf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.frame_valid (frame.valid),
	.frame_ready (frame.ready),
	.std_id      (frame.std_id),
	.ext_id      (frame.ext_id),
	.length_code (frame.length_code),
	.is_extended (frame.is_extended)
);
